// ===== rtl/apts_pkg.sv =====
// Package: shared types, constants and request codes for the aging scheduler.
package apts_pkg;

  localparam int MaxTasks = 8;
  localparam int TaskBits = 3;
  localparam int TimeBits = 32;
  localparam int PrioBits = 16;
  localparam int CountBits = 4;

  localparam logic [7:0] RealtimePrioReset = 8'd6;
  localparam logic [31:0] MinPeriodReset = 32'd100;

  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0,
    REQ_ENABLE   = 3'd1,
    REQ_DISABLE  = 3'd2,
    REQ_PERIOD   = 3'd3,
    REQ_TICK     = 3'd4
  } req_t;

  localparam logic CFG_RT_PRIO = 1'b0;
  localparam logic CFG_MIN_PERIOD = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  task_id;
    logic [7:0]  static_priority;
    logic [31:0] period;
    logic        event_driven;
    logic [31:0] current_time;
    logic [7:0]  event_flags;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        selected_valid;
    logic [2:0]  selected_task;
    logic [3:0]  waiting_count;
    logic [31:0] run_delta;
  } out_item_t;

  typedef struct packed {
    logic       cfg_index;
    logic [31:0] cfg_data;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the accepted item, run the simple request
    logic guard_step; // evaluate guard for queue slot idx
    logic age_start;  // launch divide for queue slot idx
    logic age_finish; // commit aging result for queue slot idx
    logic select;     // commit the selection
    logic [2:0] idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic guard_stop;   // guard scan ends at this slot
    logic div_done;
    logic [3:0] qlen;
  } dp_stat_t;

endpackage

// ===== rtl/apts_if.sv =====
// Interfaces: valid/ready item channels for requests, results and configuration.
interface apts_in_if (input logic clk);
  logic valid;
  logic ready;
  apts_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apts_out_if (input logic clk);
  logic valid;
  logic ready;
  apts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apts_cfg_if (input logic clk);
  logic valid;
  logic ready;
  apts_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/apts_div.sv =====
// Serial restoring divider: 32-bit quotient, one bit a cycle.
module apts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import apts_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= (divisor == '0) ? 32'd1 : divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/apts_datapath.sv =====
// Datapath: task table, enable queue, guard scan, aging and selection.
module apts_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  apts_pkg::dp_cmd_t    cmd,
  input  apts_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  apts_pkg::cfg_item_t  cfg,
  output apts_pkg::dp_stat_t   stat,
  output apts_pkg::out_item_t  result
);
  import apts_pkg::*;

  logic [7:0]  rt_prio;
  logic [31:0] min_period;

  logic [7:0]  slot_used;
  logic [7:0]  prio   [MaxTasks];
  logic [31:0] period [MaxTasks];
  logic [7:0]  is_event;
  logic [31:0] last_run [MaxTasks];
  logic [31:0] last_sig [MaxTasks];
  logic [31:0] age [MaxTasks];
  logic [15:0] dyn [MaxTasks];
  logic [2:0]  qord [MaxTasks];
  logic [3:0]  qlen;
  logic [3:0]  used_count;

  in_item_t    cur;
  logic        outside;
  logic        found;
  logic [15:0] best;
  logic [2:0]  sel;
  logic [3:0]  waiting;

  // per-slot aging scratch
  logic [2:0]  q;
  logic [2:0]  tid;
  logic        known;
  logic        reject;
  logic [31:0] clamped;
  logic        ev_path;
  logic        ev_bit;
  logic [31:0] div_num;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] new_age;
  logic [15:0] new_dyn;
  logic [39:0] prod;
  logic        age_active;
  logic [31:0] due;
  logic [31:0] diff;
  logic [8:0]  find_hit;   // bit 8 means not found
  logic [2:0]  find_pos;
  logic [2:0]  ins_pos;
  logic        ins_found;
  logic        cand;
  logic [15:0] dyn_eff;
  logic [31:0] age_eff;

  assign q = qord[cmd.idx];
  assign tid = item.task_id;
  assign known = slot_used[tid];
  assign clamped = (item.period < min_period) ? min_period : item.period;

  // reject decision for the incoming request
  always_comb begin
    reject = 1'b0;
    case (item.req_type)
      REQ_REGISTER: reject = known;
      REQ_ENABLE:   reject = !known || qlen >= used_count || !find_hit[8];
      REQ_DISABLE:  reject = !known;
      REQ_PERIOD:   reject = !known;
      REQ_TICK:     reject = 1'b0;
      default:      reject = 1'b1;
    endcase
  end

  // queue search and insertion point for the addressed slot
  always_comb begin
    find_pos = '0;
    find_hit = 9'h100;
    ins_pos = qlen[2:0];
    ins_found = 1'b0;
    for (int i = 0; i < MaxTasks; i++) begin
      if (i < int'(qlen) && qord[i] == tid && find_hit[8]) begin
        find_hit = 9'(i);
        find_pos = 3'(i);
      end
      if (i < int'(qlen) && !ins_found && prio[qord[i]] < prio[tid]) begin
        ins_found = 1'b1;
        ins_pos = 3'(i);
      end
    end
  end

  // aging for queue entry q
  assign ev_path = is_event[q] && dyn[q] == '0;
  assign ev_bit = cur.event_flags[q];
  assign div_num = is_event[q] ? cur.current_time - last_sig[q]
                               : cur.current_time - last_run[q];
  assign due = last_run[q] + period[q];
  assign diff = cur.current_time - due;

  apts_div u_div (
    .clk(clk), .rst(rst), .start(cmd.age_start),
    .dividend(div_num), .divisor(period[q]),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    age_active = 1'b0;
    new_age = '0;
    if (is_event[q]) begin
      if (!ev_path) begin
        new_age = (div_q == 32'hFFFF_FFFF) ? div_q : div_q + 32'd1;
        age_active = 1'b1;
      end else if (ev_bit) begin
        new_age = 32'd1;
        age_active = 1'b1;
      end
    end else begin
      new_age = div_q;
      age_active = div_q != '0;
    end
  end

  assign prod = 40'(prio[q]) * 40'(new_age[31:16] != '0 ? 32'hFFFF : new_age);
  assign new_dyn = (prod >= 40'hFFFF) ? 16'hFFFF : prod[15:0] + 16'd1;
  assign dyn_eff = age_active ? new_dyn : dyn[q];
  assign age_eff = new_age;
  assign cand = dyn_eff > best &&
                (outside || age_eff > 32'd1 || prio[q] == rt_prio);

  assign stat.is_tick = cur.req_type == REQ_TICK;
  assign stat.guard_stop = prio[q] < rt_prio || !diff[31];
  assign stat.div_done = div_done;
  assign stat.qlen = qlen;

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_prio <= RealtimePrioReset;
      min_period <= MinPeriodReset;
      slot_used <= '0;
      is_event <= '0;
      qlen <= '0;
      used_count <= '0;
      for (int i = 0; i < MaxTasks; i++) begin
        prio[i] <= '0;
        last_run[i] <= '0;
        last_sig[i] <= '0;
        age[i] <= '0;
        dyn[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg.cfg_index == CFG_RT_PRIO) rt_prio <= cfg.cfg_data[7:0];
        else min_period <= cfg.cfg_data;
      end
      if (cmd.load) begin
        cur <= item;
        result <= '{status: reject, default: '0};
        outside <= 1'b1;
        found <= 1'b0;
        best <= '0;
        sel <= '0;
        waiting <= '0;
        case (item.req_type)
          REQ_REGISTER: begin
            if (!reject) begin
              slot_used[tid] <= 1'b1;
              prio[tid] <= item.static_priority;
              period[tid] <= clamped;
              is_event[tid] <= item.event_driven;
              last_run[tid] <= '0;
              last_sig[tid] <= '0;
              age[tid] <= '0;
              dyn[tid] <= '0;
              used_count <= used_count + 4'd1;
            end
          end
          REQ_ENABLE: begin
            if (!reject) begin
              for (int i = 1; i < MaxTasks; i++)
                if (3'(i) > ins_pos && i <= int'(qlen)) qord[i] <= qord[i-1];
              qord[ins_pos] <= tid;
              qlen <= qlen + 4'd1;
            end
          end
          REQ_DISABLE: begin
            if (!reject && !find_hit[8]) begin
              for (int i = 0; i < MaxTasks - 1; i++)
                if (3'(i) >= find_pos && i + 1 < int'(qlen)) qord[i] <= qord[i+1];
              qlen <= qlen - 4'd1;
            end
          end
          REQ_PERIOD: begin
            if (!reject) period[tid] <= clamped;
          end
          REQ_TICK: ;
          default: ;
        endcase
      end
      if (cmd.guard_step && stat.guard_stop && prio[q] >= rt_prio) outside <= 1'b0;
      if (cmd.age_finish) begin
        age[q] <= age_eff;
        if (is_event[q] && ev_path && ev_bit) last_sig[q] <= cur.current_time;
        if (age_active) begin
          dyn[q] <= new_dyn;
          waiting <= waiting + 4'd1;
        end
        if (cand) begin
          best <= dyn_eff;
          sel <= q;
          found <= 1'b1;
        end
      end
      if (cmd.select) begin
        result <= '{status: 1'b0,
                    selected_valid: found,
                    selected_task: sel,
                    waiting_count: waiting,
                    run_delta: found ? cur.current_time - last_run[sel] : 32'd0};
        if (found) begin
          last_run[sel] <= cur.current_time;
          dyn[sel] <= '0;
        end
      end
    end
  end
endmodule

// ===== rtl/apts_ctrl.sv =====
// Controller: sequences request load, guard scan, per-entry aging and result.
module apts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  apts_pkg::dp_stat_t stat,
  output apts_pkg::dp_cmd_t  cmd
);
  import apts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_GUARD = 7'b0000100,
    S_START = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_SEL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [3:0] idx, idx_next;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.idx = idx[2:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        idx_next = '0;
        if (!stat.is_tick) state_next = S_OUT;
        else if (stat.qlen == '0) state_next = S_SEL;
        else state_next = S_GUARD;
      end
      S_GUARD: begin
        cmd.guard_step = 1'b1;
        if (stat.guard_stop || idx + 4'd1 >= stat.qlen) begin
          idx_next = '0;
          state_next = S_START;
        end else idx_next = idx + 4'd1;
      end
      S_START: begin
        cmd.age_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.age_finish = 1'b1;
          if (idx + 4'd1 >= stat.qlen) state_next = S_SEL;
          else begin
            idx_next = idx + 4'd1;
            state_next = S_START;
          end
        end
      end
      S_SEL: begin
        cmd.select = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end
endmodule

// ===== rtl/aging_priority_task_scheduler.sv =====
// Top level: aging priority task scheduler, controller plus datapath.
// Non-tick requests: S_DEC, then result in S_OUT; next item after it is taken.
// Tick: S_DEC, guard scan, divide per queued task in S_START/S_WAIT, S_SEL, S_OUT;
// the serial 32-bit divider yields one quotient bit a cycle while busy.
// One item at a time. Sync active-high reset clears table, queue; resets config.
module aging_priority_task_scheduler (
  input logic clk,
  input logic rst,
  apts_in_if.sink    req,
  apts_out_if.source rsp,
  apts_cfg_if.sink   cfg
);
  import apts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config is always accepted; the user must only write it while idle (not checked)
  assign cfg.ready = 1'b1;

  apts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  apts_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .item(req.data),
    .cfg_we(cfg.valid), .cfg(cfg.data),
    .stat(stat), .result(rsp.data)
  );
endmodule

// ===== tb/sv/tb_apts_if_note.sv =====
`timescale 1ns / 1ps
// Shared testbench types: one scheduler request item with its expected result.
package tb_apts_pkg;
  import apts_pkg::*;

  typedef struct {
    in_item_t  req;
    logic      has_gold; // expected result typed in by hand
    out_item_t gold;
  } stim_row_t;
endpackage

// ===== tb/sv/tb_aging_priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// Top-level testbench: directed table plus random requests, checked against a scheduler model.
module tb_aging_priority_task_scheduler;
  import apts_pkg::*;
  import tb_apts_pkg::*;

  logic clk;
  logic rst;
  logic failed;

  apts_in_if  req_ch (clk);
  apts_out_if rsp_ch (clk);
  apts_cfg_if cfg_ch (clk);

  aging_priority_task_scheduler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed run limit, well beyond the slowest legal run (directed rows, five phases of
  // 90 random items and the disables between them, plus receiver stalls).
  initial begin
    #40_000_000;
    $display("aging_priority_task_scheduler verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Scheduler model state
  // ---------------------------------------------------------------------
  logic [7:0]  m_rt_prio;
  logic [31:0] m_min_period;
  logic        m_used [MaxTasks];
  logic [7:0]  m_sprio [MaxTasks];
  logic [31:0] m_period [MaxTasks];
  logic        m_is_event [MaxTasks];
  logic [31:0] m_last_run [MaxTasks];
  logic [31:0] m_last_sig [MaxTasks];
  logic [31:0] m_age [MaxTasks];
  logic [15:0] m_dyn [MaxTasks];
  logic [2:0]  m_queue [MaxTasks];
  int          m_qlen;
  int          m_used_cnt;

  out_item_t pending_results[$];
  int        pending_count;

  function automatic logic [31:0] clamp_to_min(logic [31:0] p);
    return (p < m_min_period) ? m_min_period : p;
  endfunction

  function automatic logic [15:0] aged_prio(int t, logic [31:0] age);
    logic [63:0] p;
    p = 64'd1 + 64'(m_sprio[t]) * 64'(age);
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic int queue_pos(int t);
    for (int i = 0; i < m_qlen; i++)
      if (int'(m_queue[i]) == t) return i;
    return -1;
  endfunction

  // Apply one request to the model and return the result it should produce.
  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t   r;
    int          t;
    int          pos;
    int          at;
    logic        known;
    logic        outside;
    logic [15:0] best;
    logic [31:0] now;
    logic [31:0] due;
    logic [31:0] d;
    logic [31:0] dv;
    int          q;
    int          waiting;
    logic        found;
    int          sel;
    r = '0;
    t = int'(it.task_id);
    now = it.current_time;
    known = m_used[t];
    case (it.req_type)
      REQ_REGISTER: begin
        if (m_used[t]) begin
          r.status = 1'b1;
        end else begin
          m_used[t] = 1'b1;
          m_sprio[t] = it.static_priority;
          m_period[t] = clamp_to_min(it.period);
          m_is_event[t] = it.event_driven;
          m_last_run[t] = '0;
          m_last_sig[t] = '0;
          m_age[t] = '0;
          m_dyn[t] = '0;
          m_used_cnt++;
        end
      end
      REQ_ENABLE: begin
        if (!known || m_qlen >= m_used_cnt || queue_pos(t) >= 0) begin
          r.status = 1'b1;
        end else begin
          // insert after queued entries of equal static priority
          pos = m_qlen;
          for (int i = 0; i < m_qlen; i++)
            if (m_sprio[m_queue[i]] < m_sprio[t]) begin
              pos = i;
              break;
            end
          for (int i = m_qlen; i > pos; i--) m_queue[i] = m_queue[i-1];
          m_queue[pos] = t[2:0];
          m_qlen++;
        end
      end
      REQ_DISABLE: begin
        if (!known) begin
          r.status = 1'b1;
        end else begin
          at = queue_pos(t);
          if (at >= 0) begin
            for (int i = at; i + 1 < m_qlen; i++) m_queue[i] = m_queue[i+1];
            m_qlen--;
          end
        end
      end
      REQ_PERIOD: begin
        if (known) m_period[t] = clamp_to_min(it.period);
        else r.status = 1'b1;
      end
      REQ_TICK: begin
        // real-time guard: scan the run of real-time entries at the head
        outside = 1'b1;
        for (int i = 0; i < m_qlen; i++) begin
          q = int'(m_queue[i]);
          if (m_sprio[q] < m_rt_prio) break;
          due = m_last_run[q] + m_period[q];
          d = now - due;
          if (!d[31]) begin
            outside = 1'b0;
            break;
          end
        end
        best = '0;
        found = 1'b0;
        sel = 0;
        waiting = 0;
        for (int i = 0; i < m_qlen; i++) begin
          q = int'(m_queue[i]);
          dv = (m_period[q] == 0) ? 32'd1 : m_period[q];
          if (m_is_event[q]) begin
            if (m_dyn[q] > 0) begin
              d = now - m_last_sig[q];
              m_age[q] = (d / dv == 32'hFFFF_FFFF) ? d / dv : d / dv + 32'd1;
              m_dyn[q] = aged_prio(q, m_age[q]);
              waiting++;
            end else if (it.event_flags[q]) begin
              m_last_sig[q] = now;
              m_age[q] = 32'd1;
              m_dyn[q] = aged_prio(q, 32'd1);
              waiting++;
            end else begin
              m_age[q] = '0;
            end
          end else begin
            d = now - m_last_run[q];
            m_age[q] = d / dv;
            if (m_age[q] > 0) begin
              m_dyn[q] = aged_prio(q, m_age[q]);
              waiting++;
            end
          end
          if (m_dyn[q] > best &&
              (outside || m_age[q] > 1 || m_sprio[q] == m_rt_prio)) begin
            best = m_dyn[q];
            sel = q;
            found = 1'b1;
          end
        end
        if (found) begin
          r.selected_valid = 1'b1;
          r.selected_task = sel[2:0];
          r.run_delta = now - m_last_run[sel];
          m_last_run[sel] = now;
          m_dyn[sel] = '0;
        end
        r.waiting_count = (waiting > 15) ? 4'd15 : waiting[3:0];
      end
      default: r.status = 1'b1; // unknown request code
    endcase
    return r;
  endfunction

  task automatic model_reset();
    m_rt_prio = RealtimePrioReset;
    m_min_period = MinPeriodReset;
    for (int i = 0; i < MaxTasks; i++) begin
      m_used[i] = '0; m_sprio[i] = '0; m_period[i] = '0; m_is_event[i] = '0;
      m_last_run[i] = '0; m_last_sig[i] = '0; m_age[i] = '0; m_dyn[i] = '0;
      m_queue[i] = '0;
    end
    m_qlen = 0;
    m_used_cnt = 0;
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  logic no_idle; // long stretch with steady valid/ready

  function automatic logic idle_now();
    return !no_idle && ($urandom_range(99) < 22);
  endfunction

  task automatic send_request(in_item_t it, logic has_gold, out_item_t gold);
    out_item_t exp_r;
    while (idle_now()) @(posedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: predict now, before the result can come back
    exp_r = schedule_step(it);
    if (has_gold && exp_r !== gold) begin
      $display("%0t: hand-typed expectation differs: expected %h model %h",
               $time, gold, exp_r);
      failed = 1'b1;
    end
    pending_results.push_back(exp_r);
    req_ch.valid <= 1'b0;
    // block takes no new request until its result is taken anyway
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{cfg_index: idx, cfg_data: value};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_RT_PRIO) m_rt_prio = value[7:0];
    else m_min_period = value;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Result side: random stalls, compare each item with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, rsp_ch.data);
          failed = 1'b1;
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          if (e.status !== rsp_ch.data.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     rsp_ch.data.status);
          if (e.selected_valid !== rsp_ch.data.selected_valid)
            $display("%0t: selected_valid expected %0d actual %0d", $time,
                     e.selected_valid, rsp_ch.data.selected_valid);
          if (e.selected_task !== rsp_ch.data.selected_task)
            $display("%0t: selected_task expected %0d actual %0d", $time,
                     e.selected_task, rsp_ch.data.selected_task);
          if (e.waiting_count !== rsp_ch.data.waiting_count)
            $display("%0t: waiting_count expected %0d actual %0d", $time,
                     e.waiting_count, rsp_ch.data.waiting_count);
          if (e.run_delta !== rsp_ch.data.run_delta)
            $display("%0t: run_delta expected %h actual %h", $time,
                     e.run_delta, rsp_ch.data.run_delta);
          if (e !== rsp_ch.data) failed = 1'b1;
          pending_count++;
        end
      end
      rsp_ch.ready <= !idle_now();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic in_item_t mk(req_t rq, int t, int pr, logic [31:0] per,
                                  logic ev, logic [31:0] now, logic [7:0] fl);
    in_item_t it;
    it.req_type = rq;
    it.task_id = t[2:0];
    it.static_priority = pr[7:0];
    it.period = per;
    it.event_driven = ev;
    it.current_time = now;
    it.event_flags = fl;
    return it;
  endfunction

  function automatic out_item_t ok_status(logic st);
    out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // Random request, biased toward well-formed traffic and ticks.
  function automatic in_item_t random_request(ref logic [31:0] clock_us);
    in_item_t it;
    int sel;
    it = '0;
    it.task_id = 3'($urandom_range(7));
    it.static_priority = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(10));
    case ($urandom_range(3))
      0: it.period = $urandom();
      1: it.period = 32'hFFFF_FFFF;
      default: it.period = $urandom_range(1000, 1);
    endcase
    it.event_driven = 1'($urandom_range(1));
    it.event_flags = 8'($urandom_range(255));
    sel = $urandom_range(99);
    if (sel < 45) begin
      it.req_type = REQ_TICK;
      // mostly advance, sometimes jump or wrap
      if ($urandom_range(9) == 0) clock_us = $urandom();
      else clock_us = clock_us + $urandom_range(2000);
    end else if (sel < 60) it.req_type = REQ_REGISTER;
    else if (sel < 78) it.req_type = REQ_ENABLE;
    else if (sel < 88) it.req_type = REQ_DISABLE;
    else if (sel < 96) it.req_type = REQ_PERIOD;
    else it.req_type = 3'($urandom_range(7, 5));
    it.current_time = clock_us;
    return it;
  endfunction

  stim_row_t rows[$];
  logic [31:0] clock_us;

  initial begin
    out_item_t none;
    in_item_t  it;
    none = '0;
    failed = 1'b0;
    pending_count = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: empty tick, rejects, extremes, guard and saturation.
    rows.push_back('{mk(REQ_TICK, 0, 0, 1, 1'b0, 32'hFFFF_FFFF, 8'hFF), 1'b1, none});
    rows.push_back('{mk(REQ_ENABLE, 3, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b1)});
    rows.push_back('{mk(REQ_DISABLE, 3, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b1)});
    rows.push_back('{mk(REQ_PERIOD, 3, 0, 5, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b1)});
    rows.push_back('{mk(req_t'(3'd7), 0, 0, 1, 1'b0, 0, 8'h00), 1'b1,
                     ok_status(1'b1)});
    rows.push_back('{mk(req_t'(3'd5), 7, 255, 32'hFFFF_FFFF, 1'b1, 0, 8'h00), 1'b1,
                     ok_status(1'b1)});
    rows.push_back('{mk(REQ_REGISTER, 0, 255, 1, 1'b0, 0, 8'h00), 1'b1,
                     ok_status(1'b0)});
    rows.push_back('{mk(REQ_REGISTER, 0, 1, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b1)});
    rows.push_back('{mk(REQ_REGISTER, 7, 6, 32'hFFFF_FFFF, 1'b1, 0, 8'h00), 1'b1,
                     ok_status(1'b0)});
    rows.push_back('{mk(REQ_REGISTER, 2, 0, 150, 1'b0, 0, 8'h00), 1'b0, none});
    rows.push_back('{mk(REQ_ENABLE, 0, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b0)});
    rows.push_back('{mk(REQ_ENABLE, 0, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b1)});
    rows.push_back('{mk(REQ_ENABLE, 7, 0, 1, 1'b0, 0, 8'h00), 1'b0, none});
    rows.push_back('{mk(REQ_ENABLE, 2, 0, 1, 1'b0, 0, 8'h00), 1'b0, none});
    rows.push_back('{mk(REQ_ENABLE, 2, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b1)});
    rows.push_back('{mk(REQ_TICK, 0, 0, 1, 1'b0, 50, 8'h00), 1'b0, none});
    rows.push_back('{mk(REQ_TICK, 0, 0, 1, 1'b0, 32'h7FFF_FFFF, 8'h80), 1'b0, none});
    rows.push_back('{mk(REQ_TICK, 0, 0, 1, 1'b0, 32'h8000_0000, 8'h80), 1'b0, none});
    rows.push_back('{mk(REQ_PERIOD, 0, 0, 1, 1'b0, 0, 8'h00), 1'b0, none});
    rows.push_back('{mk(REQ_TICK, 0, 0, 1, 1'b0, 32'hFFFF_FFFF, 8'h7F), 1'b0, none});
    rows.push_back('{mk(REQ_DISABLE, 2, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b0)});
    rows.push_back('{mk(REQ_DISABLE, 2, 0, 1, 1'b0, 0, 8'h00), 1'b1, ok_status(1'b0)});
    rows.push_back('{mk(REQ_TICK, 0, 0, 1, 1'b0, 32'h0000_0010, 8'hFF), 1'b0, none});
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_gold, rows[i].gold);
    drain();

    // Phases over register settings; min_period 0 removes the period floor.
    clock_us = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_RT_PRIO, 32'd0); write_reg(CFG_MIN_PERIOD, 32'd1); end
        1: begin write_reg(CFG_RT_PRIO, 32'd255); write_reg(CFG_MIN_PERIOD, 32'd0); end
        2: begin
          write_reg(CFG_RT_PRIO, 32'd5);
          write_reg(CFG_MIN_PERIOD, 32'hFFFF_FFFF);
        end
        3: begin write_reg(CFG_RT_PRIO, 32'd6); write_reg(CFG_MIN_PERIOD, 32'd100); end
        default: begin
          write_reg(CFG_RT_PRIO, $urandom_range(10));
          write_reg(CFG_MIN_PERIOD, $urandom_range(500));
        end
      endcase
      // dequeue every used slot between phases so enables keep landing
      for (int t = 0; t < MaxTasks; t++)
        if (m_used[t])
          send_request(mk(REQ_DISABLE, t, 0, 1, 1'b0, 0, 8'h00), 1'b0, none);
      no_idle = (ph == 3);
      for (int n = 0; n < 90; n++) begin
        it = random_request(clock_us);
        send_request(it, 1'b0, none);
        if (ph == 2 && n == 40) drain(); // sender holds off until all results land
      end
      no_idle = 1'b0;
      drain();
    end

    if (!failed) begin
      $display("aging_priority_task_scheduler verification clean");
    end else begin
      $display("aging_priority_task_scheduler verification failed");
    end
    $finish;
  end

endmodule

// ===== aging_priority_task_scheduler.f =====
rtl/apts_pkg.sv
rtl/apts_if.sv
rtl/apts_div.sv
rtl/apts_datapath.sv
rtl/apts_ctrl.sv
rtl/aging_priority_task_scheduler.sv
tb/sv/tb_apts_if_note.sv
tb/sv/tb_aging_priority_task_scheduler.sv
